[rtl/sts_pkg.sv]
// ----------------------------------------------------------------------------
// Script token scanner package
// Shared request, response and internal item types, token kind codes, byte
// classes and the keyword table.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int TOKEN_BITS = 32;

   // Front queue and response queue geometry.
   localparam int FQ_DEPTH     = 4;
   localparam int FQ_PTR_BITS  = 2;
   localparam int FQ_CNT_BITS  = 3;
   localparam int OQ_DEPTH     = 4;
   localparam int OQ_PTR_BITS  = 2;
   localparam int OQ_CNT_BITS  = 3;

   // Token kinds. Punctuators use their index in "(){};,+-*/=" as the kind.
   localparam logic [4:0] KIND_STRING   = 5'd11;
   localparam logic [4:0] KIND_CHAR     = 5'd12;
   localparam logic [4:0] KIND_NUMBER   = 5'd13;
   localparam logic [4:0] KIND_IDENT    = 5'd14;
   localparam logic [4:0] KIND_KEYWORD0 = 5'd15;
   localparam logic [4:0] KIND_UNKNOWN  = 5'd22;
   localparam logic [4:0] KIND_END      = 5'd23;
   localparam logic [4:0] KIND_BADCHAR  = 5'd24;

   // Byte classes assigned by the front end.
   localparam logic [3:0] CLS_PUNCT   = 4'd0;
   localparam logic [3:0] CLS_QUOTE   = 4'd1;
   localparam logic [3:0] CLS_HASH    = 4'd2;
   localparam logic [3:0] CLS_APOS    = 4'd3;
   localparam logic [3:0] CLS_SPACE   = 4'd4;
   localparam logic [3:0] CLS_NEWLINE = 4'd5;
   localparam logic [3:0] CLS_DIGIT   = 4'd6;
   localparam logic [3:0] CLS_ALPHA   = 4'd7;
   localparam logic [3:0] CLS_OTHER   = 4'd8;

   // Keywords packed with the first byte in the low lane, which is why the
   // string literals read backwards.
   localparam int KW_COUNT = 7;
   localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
      56'("tel"), 56'("cnuf"), 56'("nruter"), 56'("tnirp"),
      56'("nltnirp"), 56'("eurt"), 56'("eslaf")
   };
   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd4, 4'd5
   };

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [4:0]            token_kind;
      logic [TOKEN_BITS-1:0] token_start;
      logic [TOKEN_BITS-1:0] token_length;
      logic [TOKEN_BITS-1:0] line_number;
      logic [7:0]            char_value;
      logic                  last;
   } rsp_type;

   // One classified request as it sits in the front queue.
   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
      logic [3:0] cls;
      logic [3:0] punct;
   } item_type;

   // Up to two tokens written into the response queue in one cycle.
   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type d0;
      rsp_type d1;
   } rsp_wr_type;

   function automatic item_type classify(req_type req);
      item_type item;
      item.ch          = req.ch;
      item.end_of_text = req.end_of_text;
      item.punct       = 4'd0;
      item.cls         = CLS_OTHER;
      case (req.ch)
         8'h28: begin item.cls = CLS_PUNCT; item.punct = 4'd0;  end
         8'h29: begin item.cls = CLS_PUNCT; item.punct = 4'd1;  end
         8'h7B: begin item.cls = CLS_PUNCT; item.punct = 4'd2;  end
         8'h7D: begin item.cls = CLS_PUNCT; item.punct = 4'd3;  end
         8'h3B: begin item.cls = CLS_PUNCT; item.punct = 4'd4;  end
         8'h2C: begin item.cls = CLS_PUNCT; item.punct = 4'd5;  end
         8'h2B: begin item.cls = CLS_PUNCT; item.punct = 4'd6;  end
         8'h2D: begin item.cls = CLS_PUNCT; item.punct = 4'd7;  end
         8'h2A: begin item.cls = CLS_PUNCT; item.punct = 4'd8;  end
         8'h2F: begin item.cls = CLS_PUNCT; item.punct = 4'd9;  end
         8'h3D: begin item.cls = CLS_PUNCT; item.punct = 4'd10; end
         8'h22: item.cls = CLS_QUOTE;
         8'h23: item.cls = CLS_HASH;
         8'h27: item.cls = CLS_APOS;
         8'h20, 8'h0D, 8'h09: item.cls = CLS_SPACE;
         8'h0A: item.cls = CLS_NEWLINE;
         default: begin
            if (req.ch >= 8'h30 && req.ch <= 8'h39) begin
               item.cls = CLS_DIGIT;
            end else if ((req.ch >= 8'h61 && req.ch <= 8'h7A) ||
                         (req.ch >= 8'h41 && req.ch <= 8'h5A) || req.ch == 8'h5F) begin
               item.cls = CLS_ALPHA;
            end
         end
      endcase
      return item;
   endfunction

   function automatic logic [4:0] word_kind(logic [55:0] prefix, logic [3:0] len);
      logic [4:0] kind;
      kind = KIND_IDENT;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
            kind = KIND_KEYWORD0 + 5'(k);
         end
      end
      return kind;
   endfunction

endpackage

[rtl/sts_front.sv]
// ----------------------------------------------------------------------------
// Scanner front end
// Accepts requests, classifies each byte and holds them in a short queue.
// ----------------------------------------------------------------------------
module sts_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  sts_pkg::req_type  req_data,
   output logic              item_valid,
   output sts_pkg::item_type item,
   input  logic              item_take
);
   import sts_pkg::*;

   item_type               mem_ff [FQ_DEPTH];
   logic [FQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   push_ok;
   logic                   pop_ok;

   assign full       = (count_ff == FQ_CNT_BITS'(FQ_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];
   assign push_ok    = push && !full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FQ_CNT_BITS'(push_ok) - FQ_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= classify(req_data);
      end
   end

endmodule

[rtl/sts_back.sv]
// ----------------------------------------------------------------------------
// Scanner back end
// Runs the scan state machine on one classified byte per cycle while the
// response queue has room, and forms up to two tokens for the response queue.
// ----------------------------------------------------------------------------
module sts_back #(
   parameter int POSITION_BITS = 32,
   parameter int LINE_BITS     = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  sts_pkg::item_type   item,
   output logic                item_take,
   input  logic                rsp_space,
   output sts_pkg::rsp_wr_type rsp_wr
);
   import sts_pkg::*;

   localparam logic [3:0] MODE_IDLE     = 4'd0;
   localparam logic [3:0] MODE_NUMBER   = 4'd1;
   localparam logic [3:0] MODE_IDENT    = 4'd2;
   localparam logic [3:0] MODE_STRING   = 4'd3;
   localparam logic [3:0] MODE_HASH     = 4'd4;
   localparam logic [3:0] MODE_COMMENT  = 4'd5;
   localparam logic [3:0] MODE_CH_OPEN  = 4'd6;
   localparam logic [3:0] MODE_CH_QUOTE = 4'd7;
   localparam logic [3:0] MODE_CH_CLOSE = 4'd8;

   logic [3:0]               mode_ff, mode_in;
   logic [POSITION_BITS-1:0] begin_ff, begin_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [LINE_BITS-1:0]     line_ff, line_in;
   logic [55:0]              prefix_ff, prefix_in;
   logic [3:0]               wlen_ff, wlen_in;
   logic [7:0]               lit_ff, lit_in;

   logic [POSITION_BITS-1:0] used;
   logic [POSITION_BITS-1:0] one;
   logic                     again;
   logic                     a_v, b_v;
   rsp_type                  tok_a, tok_b;

   function automatic rsp_type make_tok(logic [4:0] kind, logic [POSITION_BITS-1:0] start,
                                        logic [POSITION_BITS-1:0] len, logic [7:0] cv,
                                        logic [LINE_BITS-1:0] line);
      rsp_type t;
      t.token_kind   = kind;
      t.token_start  = TOKEN_BITS'(start);
      t.token_length = TOKEN_BITS'(len);
      t.line_number  = TOKEN_BITS'(line);
      t.char_value   = cv;
      t.last         = 1'b0;
      return t;
   endfunction

   assign item_take = item_valid && rsp_space;
   assign used      = pos_ff - begin_ff;
   assign one       = POSITION_BITS'(1);

   always_comb begin
      mode_in   = mode_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff + one;
      line_in   = line_ff;
      prefix_in = prefix_ff;
      wlen_in   = wlen_ff;
      lit_in    = lit_ff;
      again     = 1'b0;
      a_v       = 1'b0;
      b_v       = 1'b0;
      tok_a     = make_tok(KIND_UNKNOWN, begin_ff, used, 8'd0, line_ff);
      tok_b     = make_tok(KIND_UNKNOWN, pos_ff, one, 8'd0, line_ff);

      if (item.end_of_text) begin
         // Flush a pending number, word, hash or char literal, emit the end token, then start over.
         case (mode_ff)
            MODE_NUMBER: begin
               a_v   = 1'b1;
               tok_a = make_tok(KIND_NUMBER, begin_ff, used, 8'd0, line_ff);
            end
            MODE_IDENT: begin
               a_v   = 1'b1;
               tok_a = make_tok(word_kind(prefix_ff, wlen_ff), begin_ff, used, 8'd0, line_ff);
            end
            MODE_HASH: begin
               a_v   = 1'b1;
               tok_a = make_tok(KIND_UNKNOWN, begin_ff, one, 8'd0, line_ff);
            end
            MODE_CH_OPEN, MODE_CH_QUOTE, MODE_CH_CLOSE: begin
               a_v   = 1'b1;
               tok_a = make_tok(KIND_BADCHAR, begin_ff, used, 8'd0, line_ff);
            end
            default: begin
            end
         endcase
         b_v       = 1'b1;
         tok_b     = make_tok(KIND_END, pos_ff, '0, 8'd0, line_ff);
         mode_in   = MODE_IDLE;
         begin_in  = '0;
         pos_in    = '0;
         line_in   = LINE_BITS'(1);
         prefix_in = '0;
         wlen_in   = '0;
         lit_in    = '0;
      end else begin
         case (mode_ff)
            MODE_NUMBER: begin
               if (item.cls != CLS_DIGIT) begin
                  a_v   = 1'b1;
                  tok_a = make_tok(KIND_NUMBER, begin_ff, used, 8'd0, line_ff);
                  again = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (item.cls == CLS_ALPHA || item.cls == CLS_DIGIT) begin
                  for (int i = 0; i < 7; i++) begin
                     if (wlen_ff == 4'(i)) begin
                        prefix_in[8*i +: 8] = item.ch;
                     end
                  end
                  if (wlen_ff < 4'd8) begin
                     wlen_in = wlen_ff + 4'd1;
                  end
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(word_kind(prefix_ff, wlen_ff), begin_ff, used, 8'd0,
                                   line_ff);
                  again = 1'b1;
               end
            end
            MODE_STRING: begin
               if (item.cls == CLS_QUOTE) begin
                  a_v     = 1'b1;
                  tok_a   = make_tok(KIND_STRING, begin_ff + one, used - one, 8'd0, line_ff);
                  mode_in = MODE_IDLE;
               end else if (item.cls == CLS_NEWLINE) begin
                  line_in = line_ff + LINE_BITS'(1);
               end
            end
            MODE_HASH: begin
               if (item.cls == CLS_HASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(KIND_UNKNOWN, begin_ff, one, 8'd0, line_ff);
                  again = 1'b1;
               end
            end
            MODE_COMMENT: begin
               again = (item.cls == CLS_NEWLINE);
            end
            MODE_CH_OPEN: begin
               if (item.cls == CLS_APOS) begin
                  mode_in = MODE_CH_QUOTE;
               end else begin
                  lit_in  = item.ch;
                  mode_in = MODE_CH_CLOSE;
               end
            end
            MODE_CH_QUOTE: begin
               if (item.cls == CLS_APOS) begin
                  lit_in  = 8'h27;
                  mode_in = MODE_CH_CLOSE;
               end else begin
                  a_v   = 1'b1;
                  tok_a = make_tok(KIND_BADCHAR, begin_ff, used, 8'd0, line_ff);
                  again = 1'b1;
               end
            end
            MODE_CH_CLOSE: begin
               a_v = 1'b1;
               if (item.cls == CLS_APOS) begin
                  tok_a = make_tok(KIND_CHAR, begin_ff, one, lit_ff, line_ff);
               end else begin
                  tok_a = make_tok(KIND_BADCHAR, begin_ff, used + one, 8'd0, line_ff);
               end
               mode_in = MODE_IDLE;
            end
            default: begin
               again = 1'b1;
            end
         endcase

         // The byte starts a new token, either from idle or after the token
         // it ended has been flushed.
         if (again) begin
            mode_in  = MODE_IDLE;
            begin_in = pos_ff;
            case (item.cls)
               CLS_PUNCT: begin
                  b_v   = 1'b1;
                  tok_b = make_tok({1'b0, item.punct}, pos_ff, one, 8'd0, line_ff);
               end
               CLS_QUOTE:   mode_in = MODE_STRING;
               CLS_HASH:    mode_in = MODE_HASH;
               CLS_APOS: begin
                  mode_in  = MODE_CH_OPEN;
                  begin_in = pos_ff + one;
               end
               CLS_SPACE: begin
               end
               CLS_NEWLINE: line_in = line_ff + LINE_BITS'(1);
               CLS_DIGIT:   mode_in = MODE_NUMBER;
               CLS_ALPHA: begin
                  mode_in   = MODE_IDENT;
                  prefix_in = {48'd0, item.ch};
                  wlen_in   = 4'd1;
               end
               default: begin
                  b_v   = 1'b1;
                  tok_b = make_tok(KIND_UNKNOWN, pos_ff, one, 8'd0, line_ff);
               end
            endcase
         end
      end

      tok_a.last = !b_v;
      tok_b.last = 1'b1;
   end

   // Pack the tokens so that a lone token always goes in the first slot.
   always_comb begin
      rsp_wr.v0 = item_take && (a_v || b_v);
      rsp_wr.v1 = item_take && a_v && b_v;
      rsp_wr.d0 = a_v ? tok_a : tok_b;
      rsp_wr.d1 = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         begin_ff  <= '0;
         pos_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         prefix_ff <= '0;
         wlen_ff   <= '0;
         lit_ff    <= '0;
      end else if (item_take) begin
         mode_ff   <= mode_in;
         begin_ff  <= begin_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         prefix_ff <= prefix_in;
         wlen_ff   <= wlen_in;
         lit_ff    <= lit_in;
      end
   end

endmodule

[rtl/sts_rsp_queue.sv]
// ----------------------------------------------------------------------------
// Scanner response queue
// Takes up to two tokens per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module sts_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  sts_pkg::rsp_wr_type rsp_wr,
   output logic                rsp_space,
   output logic                empty,
   input  logic                pop,
   output sts_pkg::rsp_type    rsp_data
);
   import sts_pkg::*;

   rsp_type                mem_ff [OQ_DEPTH];
   logic [OQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OQ_CNT_BITS-1:0] count_ff, count_in;
   logic                   pop_ok;

   // Room for a full pair of tokens is required before an item is taken.
   assign rsp_space = (count_ff <= OQ_CNT_BITS'(OQ_DEPTH - 2));
   assign empty     = (count_ff == '0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop_ok    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OQ_PTR_BITS'(rsp_wr.v0) + OQ_PTR_BITS'(rsp_wr.v1);
      rd_ptr_in = pop_ok ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + OQ_CNT_BITS'(rsp_wr.v0) + OQ_CNT_BITS'(rsp_wr.v1)
                  - OQ_CNT_BITS'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_wr.v0) begin
         mem_ff[wr_ptr_ff] <= rsp_wr.d0;
      end
      if (rsp_wr.v1) begin
         mem_ff[wr_ptr_ff + 1'b1] <= rsp_wr.d1;
      end
   end

endmodule

[rtl/script_token_scanner.sv]
// ----------------------------------------------------------------------------
// Script token scanner
// Throughput: one request per cycle while each request yields at most one
//    token and tokens are popped as they arrive; the single-read response
//    queue limits output to one token a cycle.
// Reset: synchronous; clears both queues and returns the scanner to idle at
//    position zero on line one.
// ----------------------------------------------------------------------------
module script_token_scanner #(
   parameter int POSITION_BITS = 32,
   parameter int LINE_BITS     = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sts_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output sts_pkg::rsp_type rsp_data
);
   import sts_pkg::*;

   // The front end classifies each incoming byte (punctuator, digit, letter,
   // quote and so on) and parks the request in a four-entry queue. This keeps
   // the full flag from depending combinationally on the response side.
   item_type   item;
   logic       item_valid;
   logic       item_take;
   logic       rsp_space;
   rsp_wr_type rsp_wr;

   sts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // The back end owns the scan state: mode, token start, byte position,
   // line count and the identifier prefix used for keyword matching. One
   // request is processed per cycle while the response queue has room. A byte
   // that ends a token and then starts another (for example a digit run followed
   // by a parenthesis) produces two tokens in the same cycle, so the back end
   // only proceeds when the response queue has room for two.
   sts_back #(
      .POSITION_BITS (POSITION_BITS),
      .LINE_BITS     (LINE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_space  (rsp_space),
      .rsp_wr     (rsp_wr)
   );

   // The response queue accepts one or two tokens per cycle and presents the
   // oldest on the output ports while empty is low. The last flag marks the
   // final token caused by a request.
   sts_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_wr    (rsp_wr),
      .rsp_space (rsp_space),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/sts_checker.sv]
// ----------------------------------------------------------------------------
// Script token scanner checker
// Port-level properties of the scanner, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sts_checker (
   input logic             clock,
   input logic             reset,
   input logic             full,
   input logic             empty,
   input logic             pop,
   input sts_pkg::rsp_type rsp_data
);
   import sts_pkg::*;

   // Both queues are drained by reset.
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");

   // An end token is always the final token of its request.
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.token_kind == KIND_END |-> rsp_data.last)
      else $error("end token without last");

   // Only char literal tokens carry a character value.
   assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.token_kind != KIND_CHAR |-> rsp_data.char_value == 8'd0)
      else $error("char value on non-char token");

   // A waiting response that is not popped stays put.
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("response changed while stalled");

endmodule

bind script_token_scanner sts_checker u_sts_checker (.*);
